>>> sv/lock_grant_revoke_retry_macros.svh
// Assertion macros used by the lock server top level.
`ifndef LOCK_GRANT_REVOKE_RETRY_MACROS_SVH
`define LOCK_GRANT_REVOKE_RETRY_MACROS_SVH

// Plain property, sampled on clk, off while reset is asserted.
`define LGRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define LGRR_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/lgrr_pkg.sv
// Types, sizes and codes shared by the lock server modules.
package lgrr_pkg;

    localparam int LOCK_COUNT  = 256;
    localparam int CLIENT_BITS = 8;
    localparam int WAIT_DEPTH  = 8;

    localparam int LOCK_AW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int HEAD_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int COUNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int WADDR_W = $clog2(LOCK_COUNT * WAIT_DEPTH);

    typedef enum logic [1:0] {
        MODE_FREE,
        MODE_LOCKED,
        MODE_REVOKING,
        MODE_RETRYING
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_RETRY,
        STATUS_FULL
    } status_t;

    typedef enum logic [1:0] {
        NOTICE_NONE,
        NOTICE_REVOKE,
        NOTICE_RETRY
    } notice_t;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        mode_t                  mode;
        logic [CLIENT_BITS-1:0] owner;
        logic [CLIENT_BITS-1:0] invited;
        logic [HEAD_W-1:0]      head;
        logic [COUNT_W-1:0]     count;
    } lock_entry_t;

    typedef struct packed {
        lock_entry_t            entry;
        logic                   wr_en;
        logic [HEAD_W-1:0]      wr_pos;
        status_t                status;
        notice_t                kind;
        logic [CLIENT_BITS-1:0] who;
    } decision_t;

endpackage

>>> sv/lgrr_decide.sv
// Per-request grant / queue / release decision for one lock entry.
module lgrr_decide
    import lgrr_pkg::*;
(
    input  logic                   cmd,
    input  logic [CLIENT_BITS-1:0] client,
    input  lock_entry_t            entry,
    input  logic [CLIENT_BITS-1:0] first_waiter,
    output decision_t              dec
);

    logic                   grant;
    logic [HEAD_W-1:0]      head_inc;
    logic [COUNT_W:0]       tail_sum;
    logic [COUNT_W:0]       tail_pos;
    logic [COUNT_W-1:0]     cnt;

    always_comb
    begin
        grant = (entry.mode == MODE_FREE) ||
                ((entry.mode == MODE_RETRYING) && (entry.invited == client));

        if (entry.head == HEAD_W'(WAIT_DEPTH - 1))
            head_inc = '0;
        else
            head_inc = entry.head + HEAD_W'(1);

        // tail slot = (head + count) mod depth, sum stays below twice the depth
        tail_sum = (COUNT_W+1)'(entry.head) + (COUNT_W+1)'(entry.count);
        if (tail_sum >= (COUNT_W+1)'(WAIT_DEPTH))
            tail_pos = tail_sum - (COUNT_W+1)'(WAIT_DEPTH);
        else
            tail_pos = tail_sum;

        cnt        = entry.count;
        dec        = '0;
        dec.entry  = entry;
        dec.status = STATUS_OK;
        dec.kind   = NOTICE_NONE;
        dec.wr_pos = HEAD_W'(tail_pos);

        if (cmd == CMD_ACQUIRE)
        begin
            if (grant)
            begin
                // invited client leaves the queue on its grant
                if ((entry.mode != MODE_FREE) && (entry.count != '0))
                begin
                    dec.entry.head = head_inc;
                    cnt            = entry.count - COUNT_W'(1);
                end
                dec.entry.count = cnt;
                dec.entry.owner = client;
                dec.entry.mode  = MODE_LOCKED;
                if (cnt != '0)
                begin
                    dec.entry.mode = MODE_REVOKING;
                    dec.kind       = NOTICE_REVOKE;
                    dec.who        = client;
                end
            end
            else if (entry.count >= COUNT_W'(WAIT_DEPTH))
            begin
                dec.status = STATUS_FULL;
            end
            else
            begin
                dec.wr_en       = 1'b1;
                dec.entry.count = entry.count + COUNT_W'(1);
                dec.status      = STATUS_RETRY;
                if (entry.mode == MODE_LOCKED)
                begin
                    dec.entry.mode = MODE_REVOKING;
                    dec.kind       = NOTICE_REVOKE;
                    dec.who        = entry.owner;
                end
            end
        end
        else
        begin
            dec.entry.mode = MODE_FREE;
            if (entry.count != '0)
            begin
                dec.entry.mode    = MODE_RETRYING;
                dec.entry.invited = first_waiter;
                dec.kind          = NOTICE_RETRY;
                dec.who           = first_waiter;
            end
        end
    end

endmodule

>>> sv/lock_grant_revoke_retry.sv
// Top level of the caching lock server with revoke and retry notices.
//
// Lock server over a table of LOCK_COUNT locks (256). Each request transaction
// (acquire or release, lock id, client id) yields exactly one result
// transaction: a status plus an optional revoke or retry notice for some
// client. Acceptance reads the lock entry memory. The fetch state then reads
// the waiter queue memory at the slot that the entry's head points at. The
// execute state decides, writes both memories back and loads the result
// register. No new request is accepted until that write-back is done.
// Requests run one at a time, so a lock entry is never read while a write to
// it is still pending. The result sits in an output register; the next
// request is accepted while it waits, and the write-back stalls only if a
// result is still untaken when the next one is ready.
// After reset the block sweeps the lock table to the free state, one entry
// per cycle; no request is accepted during the sweep. Waiter queue slots are
// not cleared: the rules never read them before they are written.
`include "lock_grant_revoke_retry_macros.svh"

module lock_grant_revoke_retry
    import lgrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] lock_id,
    input  logic [7:0] client_id,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [1:0] notice_kind,
    output logic [7:0] notice_client,
    output logic [7:0] notice_lock
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;

    logic [LOCK_AW-1:0]     clr_reg;
    logic                   cmd_reg;
    logic [7:0]             lid_reg;
    logic [LOCK_AW-1:0]     lk_reg;
    logic [CLIENT_BITS-1:0] client_reg;

    logic                   out_valid_reg;
    status_t                status_reg;
    notice_t                kind_reg;
    logic [7:0]             who_reg;
    logic [7:0]             nlock_reg;

    // lock table and waiter queues
    lock_entry_t            ent_mem [LOCK_COUNT];
    lock_entry_t            ent_rd_reg;
    logic [CLIENT_BITS-1:0] wt_mem [LOCK_COUNT * WAIT_DEPTH];
    logic [CLIENT_BITS-1:0] wt_rd_reg;

    logic                   in_fire;
    logic                   exec_fire;
    logic [LOCK_AW-1:0]     lk_in;
    logic                   ent_we;
    logic [LOCK_AW-1:0]     ent_waddr;
    lock_entry_t            ent_wdata;
    logic                   wt_re;
    logic [WADDR_W-1:0]     wt_raddr;
    logic                   wt_we;
    logic [WADDR_W-1:0]     wt_waddr;
    decision_t              dec;

    lgrr_decide u_decide
    (
        .cmd          (cmd_reg),
        .client       (client_reg),
        .entry        (ent_rd_reg),
        .first_waiter (wt_rd_reg),
        .dec          (dec)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    // lock ids are taken modulo the table size; every 8-bit id fits the 256 locks
    assign lk_in = LOCK_AW'(32'(lock_id) % LOCK_COUNT);

    always_comb
    begin
        ent_we    = (state_reg == S_CLEAR) || exec_fire;
        ent_waddr = (state_reg == S_CLEAR) ? clr_reg : lk_reg;
        ent_wdata = (state_reg == S_CLEAR) ? lock_entry_t'('0) : dec.entry;

        wt_re    = (state_reg == S_FETCH);
        wt_raddr = WADDR_W'(lk_reg) * WADDR_W'(WAIT_DEPTH) + WADDR_W'(ent_rd_reg.head);
        wt_we    = exec_fire && dec.wr_en;
        wt_waddr = WADDR_W'(lk_reg) * WADDR_W'(WAIT_DEPTH) + WADDR_W'(dec.wr_pos);
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        if (in_fire)
            ent_rd_reg <= ent_mem[lk_in];
    end

    always_ff @(posedge clk)
    begin
        if (wt_we)
            wt_mem[wt_waddr] <= client_reg;
        if (wt_re)
            wt_rd_reg <= wt_mem[wt_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_reg == LOCK_AW'(LOCK_COUNT - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (in_fire)
                    state_next = S_FETCH;
            S_FETCH:
                state_next = S_EXEC;
            S_EXEC:
                if (exec_fire)
                    state_next = S_IDLE;
            default:
                state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cmd_reg       <= CMD_ACQUIRE;
            lid_reg       <= '0;
            lk_reg        <= '0;
            client_reg    <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_OK;
            kind_reg      <= NOTICE_NONE;
            who_reg       <= '0;
            nlock_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + LOCK_AW'(1);

            if (in_fire)
            begin
                cmd_reg    <= cmd;
                lid_reg    <= lock_id;
                lk_reg     <= lk_in;
                client_reg <= CLIENT_BITS'(client_id);
            end

            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= dec.status;
                kind_reg      <= dec.kind;
                if (dec.kind != NOTICE_NONE)
                begin
                    who_reg   <= 8'(dec.who);
                    nlock_reg <= lid_reg;
                end
                else
                begin
                    who_reg   <= '0;
                    nlock_reg <= '0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign notice_kind   = kind_reg;
    assign notice_client = who_reg;
    assign notice_lock   = nlock_reg;

    `LGRR_ASSERT(a_accept_to_fetch, in_fire |=> (state_reg == S_FETCH),
                 "accept did not start fetch")
    `LGRR_ASSERT(a_exec_holds,
                 ((state_reg == S_EXEC) && out_valid_reg && !out_ready) |=> (state_reg == S_EXEC),
                 "write-back overran a pending result")
    `LGRR_IMPLY(a_no_accept_in_clear, (state_reg == S_CLEAR), !in_ready,
                "request taken during table sweep")
    `LGRR_IMPLY(a_quiet_no_notice, (out_valid && (notice_kind == NOTICE_NONE)),
                ((notice_client == 8'd0) && (notice_lock == 8'd0)),
                "notice fields set with no notice")
    `LGRR_IMPLY(a_full_no_notice, (out_valid && (status == STATUS_FULL)),
                (notice_kind == NOTICE_NONE), "queue-full result carries a notice")

endmodule
